/* hw/rtl/fct_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the chain table engine.
package fct_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Link marker codes; every value at or above LINK_META is a marker
  localparam logic [31:0] LINK_FREE = 32'hffff_ffff;
  localparam logic [31:0] LINK_EOC  = 32'hffff_fffe;
  localparam logic [31:0] LINK_META = 32'hffff_fffc;

  // Operation codes
  localparam logic [2:0] OP_SET    = 3'd0;
  localparam logic [2:0] OP_LINK   = 3'd1;
  localparam logic [2:0] OP_FOLLOW = 3'd2;
  localparam logic [2:0] OP_FIND   = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  // Result status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_RANGE  = 3'd1;
  localparam logic [2:0] ST_BROKEN = 3'd2;
  localparam logic [2:0] ST_LOOP   = 3'd3;
  localparam logic [2:0] ST_FULL   = 3'd4;

  // Source of the result index
  typedef enum logic [1:0] {
    IDX_ZERO,
    IDX_POS,
    IDX_CUR,
    IDX_SCAN
  } idx_sel_t;

  typedef struct packed {
    logic       load;
    logic       set_write;
    logic       link_write;
    logic       chain_drop;
    logic       clear;
    logic       walk_start;
    logic       walk_step;
    logic       scan_start;
    logic       scan_next;
    logic       read_scan;
    logic       emit;
    idx_sel_t   idx_sel;
    logic [2:0] status;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       pos_in_range;
    logic       pos_marker;
    logic       cur_in_range;
    logic       cur_marker;
    logic       steps_done;
    logic       entry_free;
    logic       scan_end;
    logic       slot_free;
  } sts_t;

endpackage

/* hw/rtl/fct_dp.sv */
// Datapath: item registers, link table, walk and scan counters, result register.
module fct_dp (
  input  logic                clk,
  input  logic                rst,
  input  fct_pkg::cmd_t       cmd,
  output fct_pkg::sts_t       sts,
  input  logic [2:0]          operation,
  input  logic [31:0]         position,
  input  logic [31:0]         link_value,
  input  logic                chain_last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         found_index,
  output logic [2:0]          status,
  output logic                last
);

  logic [2:0]                op_q;
  logic [31:0]               pos_q;
  logic [31:0]               val_q;
  logic                      chain_last_q;
  logic [31:0]               table_data [fct_pkg::TABLE_DEPTH];
  logic [fct_pkg::TABLE_DEPTH-1:0] table_valid;
  logic [fct_pkg::IDX_W-1:0] prev_idx;
  logic                      prev_valid;
  logic [31:0]               cur;
  logic [fct_pkg::CNT_W-1:0] steps;
  logic [fct_pkg::IDX_W-1:0] scan_idx;
  logic [fct_pkg::IDX_W-1:0] pos_idx;
  logic [fct_pkg::IDX_W-1:0] rd_addr;
  logic [31:0]               rd_data;
  logic [31:0]               idx_mux;

  assign pos_idx = pos_q[fct_pkg::IDX_W-1:0];

  // Single table read port: scan pointer or walk pointer
  assign rd_addr = cmd.read_scan ? scan_idx : cur[fct_pkg::IDX_W-1:0];
  assign rd_data = table_valid[rd_addr] ? table_data[rd_addr] : fct_pkg::LINK_FREE;

  // Capture the item on transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q         <= operation;
      pos_q        <= position;
      val_q        <= link_value;
      chain_last_q <= chain_last;
    end
  end

  // Table entries; end-of-chain write wins over the previous-link write
  always_ff @(posedge clk) begin
    for (int k = 0; k < fct_pkg::TABLE_DEPTH; k++) begin
      if (cmd.set_write && pos_idx == fct_pkg::IDX_W'(k)) begin
        table_data[k] <= val_q;
      end else if (cmd.link_write && chain_last_q && pos_idx == fct_pkg::IDX_W'(k)) begin
        table_data[k] <= fct_pkg::LINK_EOC;
      end else if (cmd.link_write && prev_valid && prev_idx == fct_pkg::IDX_W'(k)) begin
        table_data[k] <= pos_q;
      end
    end
  end

  // Entry valid bits: unwritten entries read as free
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      table_valid <= '0;
    end else begin
      for (int k = 0; k < fct_pkg::TABLE_DEPTH; k++) begin
        if (((cmd.set_write || (cmd.link_write && chain_last_q)) &&
             pos_idx == fct_pkg::IDX_W'(k)) ||
            (cmd.link_write && prev_valid && prev_idx == fct_pkg::IDX_W'(k))) begin
          table_valid[k] <= 1'b1;
        end
      end
    end
  end

  // Pending chain element
  always_ff @(posedge clk) begin
    if (rst || cmd.clear || cmd.chain_drop) begin
      prev_idx   <= '0;
      prev_valid <= 1'b0;
    end else if (cmd.link_write) begin
      if (chain_last_q) begin
        prev_idx   <= '0;
        prev_valid <= 1'b0;
      end else begin
        prev_idx   <= pos_idx;
        prev_valid <= 1'b1;
      end
    end
  end

  // Walk pointer and step count
  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      cur   <= pos_q;
      steps <= '0;
    end else if (cmd.walk_step) begin
      cur   <= rd_data;
      steps <= steps + fct_pkg::CNT_W'(1);
    end
  end

  // Free-entry scan pointer
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx <= '0;
    end else if (cmd.scan_next) begin
      scan_idx <= scan_idx + fct_pkg::IDX_W'(1);
    end
  end

  // Select the result index
  always_comb begin
    case (cmd.idx_sel)
      fct_pkg::IDX_POS:  idx_mux = pos_q;
      fct_pkg::IDX_CUR:  idx_mux = cur;
      fct_pkg::IDX_SCAN: idx_mux = 32'(scan_idx);
      default:           idx_mux = '0;
    endcase
  end

  // Result register: load on emit, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      found_index <= idx_mux;
      status      <= cmd.status;
      last        <= cmd.last;
    end
  end

  // Status toward the controller
  always_comb begin
    sts.op           = op_q;
    sts.pos_in_range = pos_q < 32'(fct_pkg::TABLE_DEPTH);
    sts.pos_marker   = pos_q >= fct_pkg::LINK_META;
    sts.cur_in_range = cur < 32'(fct_pkg::TABLE_DEPTH);
    sts.cur_marker   = cur >= fct_pkg::LINK_META;
    sts.steps_done   = steps == fct_pkg::CNT_W'(fct_pkg::TABLE_DEPTH);
    sts.entry_free   = rd_data == fct_pkg::LINK_FREE;
    sts.scan_end     = scan_idx == fct_pkg::IDX_W'(fct_pkg::TABLE_DEPTH - 1);
    sts.slot_free    = !out_valid || out_ready;
  end

endmodule

/* hw/rtl/fct_ctrl.sv */
// Controller: sequences each operation and issues datapath commands.
module fct_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  fct_pkg::sts_t sts,
  output fct_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_SCAN
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // Command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.slot_free) begin
          state_next = S_IDLE;
          cmd.emit   = 1'b1;
          cmd.last   = 1'b1;
          unique case (sts.op)
            fct_pkg::OP_SET: begin
              cmd.set_write = sts.pos_in_range;
              cmd.status    = sts.pos_in_range ? fct_pkg::ST_OK : fct_pkg::ST_RANGE;
            end
            fct_pkg::OP_LINK: begin
              cmd.idx_sel    = fct_pkg::IDX_POS;
              cmd.link_write = sts.pos_in_range;
              cmd.chain_drop = !sts.pos_in_range;
              cmd.status     = sts.pos_in_range ? fct_pkg::ST_OK : fct_pkg::ST_RANGE;
            end
            fct_pkg::OP_FOLLOW: begin
              if (sts.pos_marker) begin
                cmd.status = fct_pkg::ST_OK;
              end else if (!sts.pos_in_range) begin
                cmd.status = fct_pkg::ST_RANGE;
              end else begin
                cmd.emit       = 1'b0;
                cmd.last       = 1'b0;
                cmd.walk_start = 1'b1;
                state_next     = S_WALK;
              end
            end
            fct_pkg::OP_FIND: begin
              cmd.emit       = 1'b0;
              cmd.last       = 1'b0;
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
            fct_pkg::OP_CLEAR: begin
              cmd.clear  = 1'b1;
              cmd.status = fct_pkg::ST_OK;
            end
            default: begin
              cmd.status = fct_pkg::ST_RANGE;
            end
          endcase
        end
      end
      S_WALK: begin
        // One table read per emitted chain element
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          if (sts.cur_in_range && !sts.steps_done) begin
            cmd.idx_sel   = fct_pkg::IDX_CUR;
            cmd.status    = fct_pkg::ST_OK;
            cmd.walk_step = 1'b1;
          end else begin
            cmd.last   = 1'b1;
            state_next = S_IDLE;
            if (sts.cur_in_range) begin
              cmd.status = fct_pkg::ST_LOOP;
            end else begin
              cmd.status = sts.cur_marker ? fct_pkg::ST_OK : fct_pkg::ST_BROKEN;
            end
          end
        end
      end
      S_SCAN: begin
        // Advance one entry per cycle while the result register has room, until a free one or the end
        cmd.read_scan = 1'b1;
        if (sts.slot_free) begin
          if (sts.entry_free) begin
            cmd.emit    = 1'b1;
            cmd.last    = 1'b1;
            cmd.idx_sel = fct_pkg::IDX_SCAN;
            cmd.status  = fct_pkg::ST_OK;
            state_next  = S_IDLE;
          end else if (sts.scan_end) begin
            cmd.emit   = 1'b1;
            cmd.last   = 1'b1;
            cmd.status = fct_pkg::ST_FULL;
            state_next = S_IDLE;
          end else begin
            cmd.scan_next = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Never load the result register while it still holds an untaken result
  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.slot_free)
    else $error("result emitted into an occupied result register");

  // A transferred item always goes to execution next
  a_load_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_EXEC))
    else $error("accepted item not executed");

  // The walk never steps past the table depth
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_step |-> !sts.steps_done)
    else $error("chain walk exceeded table depth");

  // A stalled walk holds its place
  a_walk_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && !sts.slot_free) |=> (state == S_WALK))
    else $error("walk left while result register was full");

endmodule

/* hw/rtl/fat_chain_table_engine.sv */
// Top level: chain table engine built from a controller and a datapath.
// A table of TABLE_DEPTH 32-bit next-entry links (markers: free, end of chain,
// table block, meta-table block) with set, chain link, follow, find free and clear
// operations; every item gives one result, except follow, which gives one result
// per visited entry plus a terminal status. An item is transferred in while idle and
// then executed in a separate state. Follow emits up to TABLE_DEPTH chain elements,
// reading one table entry per emitted element, then the terminal status. Find free
// scans one entry per cycle from entry 0 while the result register has room, and
// reports the first free entry, or full when none is free. The next item is taken
// as soon as the previous one has issued its last result into the output register,
// even while that result waits; a full output register stalls execution.
module fat_chain_table_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [31:0] position,
  input  logic [31:0] link_value,
  input  logic        chain_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] found_index,
  output logic [2:0]  status,
  output logic        last
);

  fct_pkg::cmd_t cmd;
  fct_pkg::sts_t sts;

  // Sequencer
  fct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table and result path
  fct_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .operation   (operation),
    .position    (position),
    .link_value  (link_value),
    .chain_last  (chain_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found_index (found_index),
    .status      (status),
    .last        (last)
  );

endmodule

/* bench/chain_table_checker.sv */
// Checker for the chain table engine: mirrors the link table and checks every result transfer.
module chain_table_checker
  import fct_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [31:0] position,
  input  logic [31:0] link_value,
  input  logic        chain_last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] found_index,
  input  logic [2:0]  status,
  input  logic        last,
  output int          mismatches,
  output int          results_seen,
  output int          results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] DEPTH_32 = TABLE_DEPTH;

  typedef struct packed {
    logic [31:0] index;
    logic [2:0]  code;
    logic        fin;
  } walk_result_t;

  logic [31:0]      shadow_links [TABLE_DEPTH];
  logic [IDX_W-1:0] chain_prev_idx;
  logic             chain_open;
  walk_result_t     due_results [$];
  walk_result_t     oldest;

  function automatic logic is_marker(input logic [31:0] v);
    return v >= LINK_META;
  endfunction

  task automatic push_result(input logic [31:0] idx, input logic [2:0] code, input logic fin);
    walk_result_t r;
    r.index = idx;
    r.code  = code;
    r.fin   = fin;
    due_results = {due_results, r};
  endtask

  task automatic clear_shadow();
    for (int k = 0; k < TABLE_DEPTH; k++) shadow_links[k] = LINK_FREE;
    chain_prev_idx = '0;
    chain_open     = 1'b0;
  endtask

  // Update the shadow table and queue the results one input transfer causes
  task automatic apply_table_op(input logic [2:0] op, input logic [31:0] pos,
                                input logic [31:0] val, input logic fin);
    logic [31:0] walk;
    int          hops;
    logic        hit;
    case (op)
      OP_SET: begin
        if (pos < DEPTH_32) begin
          shadow_links[pos[IDX_W-1:0]] = val;
          push_result('0, ST_OK, 1'b1);
        end else begin
          push_result('0, ST_RANGE, 1'b1);
        end
      end
      OP_LINK: begin
        if (pos >= DEPTH_32) begin
          // out-of-range element drops the chain in progress
          chain_open     = 1'b0;
          chain_prev_idx = '0;
          push_result(pos, ST_RANGE, 1'b1);
        end else begin
          if (chain_open) shadow_links[chain_prev_idx] = pos;
          if (fin) begin
            shadow_links[pos[IDX_W-1:0]] = LINK_EOC;
            chain_open     = 1'b0;
            chain_prev_idx = '0;
          end else begin
            chain_prev_idx = pos[IDX_W-1:0];
            chain_open     = 1'b1;
          end
          push_result(pos, ST_OK, 1'b1);
        end
      end
      OP_FOLLOW: begin
        if (is_marker(pos)) begin
          push_result('0, ST_OK, 1'b1);
        end else if (pos >= DEPTH_32) begin
          push_result('0, ST_RANGE, 1'b1);
        end else begin
          // walk until a value leaves the table or every entry has been emitted
          walk = pos;
          hops = 0;
          while (walk < DEPTH_32 && hops < TABLE_DEPTH) begin
            push_result(walk, ST_OK, 1'b0);
            walk = shadow_links[walk[IDX_W-1:0]];
            hops++;
          end
          if (walk < DEPTH_32) push_result('0, ST_LOOP, 1'b1);
          else push_result('0, is_marker(walk) ? ST_OK : ST_BROKEN, 1'b1);
        end
      end
      OP_FIND: begin
        hit = 1'b0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
          if (!hit && shadow_links[k] == LINK_FREE) begin
            hit = 1'b1;
            push_result(32'(k), ST_OK, 1'b1);
          end
        end
        if (!hit) push_result('0, ST_FULL, 1'b1);
      end
      OP_CLEAR: begin
        clear_shadow();
        push_result('0, ST_OK, 1'b1);
      end
      default: push_result('0, ST_RANGE, 1'b1);
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h (result %0d)",
             $realtime, what, got, want, results_seen);
    mismatches++;
  endtask

  // Compare the result transfer first, then predict from the input transfer
  always @(posedge clk) begin
    if (rst) begin
      clear_shadow();
      due_results.delete();
      mismatches   = 0;
      results_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          report_mismatch("result with nothing due, index", found_index, '0);
        end else begin
          oldest = due_results.pop_front();
          if (found_index !== oldest.index) report_mismatch("found_index", found_index, oldest.index);
          if (status !== oldest.code) report_mismatch("status", 32'(status), 32'(oldest.code));
          if (last !== oldest.fin) report_mismatch("last", 32'(last), 32'(oldest.fin));
        end
      end
      if (in_valid && in_ready) apply_table_op(operation, position, link_value, chain_last);
    end
    results_pending = due_results.size();
  end

endmodule

/* bench/fat_chain_table_engine_test.sv */
// Testbench top for the chain table engine: stimulus, receiver stalls, watchdog and verdict.
module fat_chain_table_engine_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fct_pkg::*;

  localparam logic [31:0] LINK_TABLE_BLK  = 32'hffff_fffd;
  localparam int          ITEM_TARGET     = 250;
  localparam int          IDLE_LIMIT      = 3000;
  localparam int          HOLD_OFF_CYCLES = 160;
  localparam int          DRAIN_CYCLES    = 40;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  operation;
  logic [31:0] position;
  logic [31:0] link_value;
  logic        chain_last;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] found_index;
  logic [2:0]  status;
  logic        last;

  int   mismatches;
  int   results_seen;
  int   results_pending;
  int   items_sent;
  int   quiet_cycles;
  int   send_idle_pct;
  int   recv_idle_pct;
  logic held_off;

  fat_chain_table_engine DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .position   (position),
    .link_value (link_value),
    .chain_last (chain_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .found_index(found_index),
    .status     (status),
    .last       (last)
  );

  chain_table_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .position       (position),
    .link_value     (link_value),
    .chain_last     (chain_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .found_index    (found_index),
    .status         (status),
    .last           (last),
    .mismatches     (mismatches),
    .results_seen   (results_seen),
    .results_pending(results_pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one item after a random gap and hold it until the transfer
  task automatic offer_op(input logic [2:0] op, input logic [31:0] pos,
                          input logic [31:0] val, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    position   <= pos;
    link_value <= val;
    chain_last <= fin;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  function automatic logic [31:0] pick_position();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return $urandom_range(TABLE_DEPTH - 1);
    if (roll < 80) return LINK_META + $urandom_range(3);
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_link();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return $urandom_range(TABLE_DEPTH - 1);
    if (roll < 85) return LINK_META + $urandom_range(3);
    return $urandom();
  endfunction

  // Noise: any operation with loosely shaped fields
  task automatic random_item();
    int         roll;
    logic [2:0] op;
    roll = $urandom_range(99);
    if (roll < 25) op = OP_SET;
    else if (roll < 50) op = OP_LINK;
    else if (roll < 75) op = OP_FOLLOW;
    else if (roll < 95) op = OP_FIND;
    else op = OP_CLEAR;
    offer_op(op, pick_position(), pick_link(), 1'($urandom_range(1)));
  endtask

  // Stream a chain, now and then broken by an out-of-range element, then walk it
  task automatic link_chain(input int len);
    logic [31:0] head;
    logic [31:0] pos;
    head = $urandom_range(TABLE_DEPTH - 1);
    for (int k = 0; k < len; k++) begin
      pos = (k == 0) ? head : 32'($urandom_range(TABLE_DEPTH - 1));
      if (k > 0 && $urandom_range(19) == 0) pos = TABLE_DEPTH + $urandom();
      offer_op(OP_LINK, pos, $urandom(), k == len - 1);
    end
    offer_op(OP_FOLLOW, head, $urandom(), 1'($urandom_range(1)));
  endtask

  // Link every entry into one shuffled chain, walk it, then close it into a ring
  task automatic fill_and_walk();
    int order [TABLE_DEPTH];
    int j;
    int swap;
    for (int k = 0; k < TABLE_DEPTH; k++) order[k] = k;
    for (int k = TABLE_DEPTH - 1; k > 0; k--) begin
      j        = $urandom_range(k);
      swap     = order[k];
      order[k] = order[j];
      order[j] = swap;
    end
    offer_op(OP_CLEAR, $urandom(), $urandom(), 1'($urandom_range(1)));
    for (int k = 0; k < TABLE_DEPTH; k++)
      offer_op(OP_LINK, order[k], $urandom(), k == TABLE_DEPTH - 1);
    offer_op(OP_FIND, $urandom(), $urandom(), 1'($urandom_range(1)));
    offer_op(OP_FOLLOW, order[0], $urandom(), 1'($urandom_range(1)));
    offer_op(OP_SET, order[TABLE_DEPTH - 1], order[0], 1'($urandom_range(1)));
    offer_op(OP_FOLLOW, order[$urandom_range(TABLE_DEPTH - 1)], $urandom(),
             1'($urandom_range(1)));
    offer_op(OP_FIND, $urandom(), $urandom(), 1'($urandom_range(1)));
  endtask

  task automatic run_random(input int upto);
    int roll;
    while (items_sent < upto) begin
      roll = $urandom_range(99);
      if (roll < 40) link_chain($urandom_range(8, 1));
      else if (roll < 45) fill_and_walk();
      else if (roll < 55)
        offer_op(OP_SET, $urandom_range(TABLE_DEPTH - 1), $urandom_range(TABLE_DEPTH - 1),
                 1'($urandom_range(1)));
      else if (roll < 65)
        offer_op(OP_FOLLOW, $urandom_range(TABLE_DEPTH - 1), $urandom(),
                 1'($urandom_range(1)));
      else random_item();
    end
  endtask

  task automatic run_directed();
    // empty table: first free entry, then range extremes of set
    offer_op(OP_FIND, 32'd0, 32'd0, 1'b0);
    offer_op(OP_SET, TABLE_DEPTH - 1, 32'd0, 1'b0);
    offer_op(OP_SET, 32'd0, 32'hffff_fff0, 1'b1);
    offer_op(OP_SET, TABLE_DEPTH, 32'd5, 1'b0);
    offer_op(OP_SET, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
    // broken chain: last entry leads through entry 0 into a non-marker out-of-range value
    offer_op(OP_FOLLOW, TABLE_DEPTH - 1, 32'd0, 1'b0);
    // follow from each marker, then from out-of-range starts
    offer_op(OP_FOLLOW, LINK_FREE, 32'd0, 1'b0);
    offer_op(OP_FOLLOW, LINK_EOC, 32'd0, 1'b0);
    offer_op(OP_FOLLOW, LINK_TABLE_BLK, 32'd0, 1'b0);
    offer_op(OP_FOLLOW, LINK_META, 32'd0, 1'b0);
    offer_op(OP_FOLLOW, TABLE_DEPTH, 32'd0, 1'b0);
    offer_op(OP_FOLLOW, 32'hffff_fffb, 32'd0, 1'b0);
    // short well-formed chain and its walk
    offer_op(OP_LINK, 32'd3, 32'd0, 1'b0);
    offer_op(OP_LINK, 32'd7, 32'hffff_ffff, 1'b0);
    offer_op(OP_LINK, 32'd12, 32'd0, 1'b1);
    offer_op(OP_FOLLOW, 32'd3, 32'd0, 1'b0);
    // chain dropped by an out-of-range element
    offer_op(OP_LINK, 32'd5, 32'd0, 1'b0);
    offer_op(OP_LINK, 32'd40, 32'd0, 1'b0);
    offer_op(OP_LINK, 32'd9, 32'd0, 1'b1);
    // close 3 -> 7 -> 12 into a loop and walk it
    offer_op(OP_SET, 32'd12, 32'd3, 1'b0);
    offer_op(OP_FOLLOW, 32'd7, 32'd0, 1'b0);
    offer_op(OP_FIND, 32'd0, 32'd0, 1'b0);
    offer_op(OP_CLEAR, 32'd0, 32'd0, 1'b0);
    offer_op(OP_FIND, 32'd0, 32'd0, 1'b1);
  endtask

  // Receiver: random stalls, plus one long hold-off once idling stops
  initial begin
    out_ready = 1'b0;
    held_off  = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (recv_idle_pct == 0 && !held_off) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      @(posedge clk);
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results still due",
               IDLE_LIMIT, results_pending);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    operation     = OP_SET;
    position      = '0;
    link_value    = '0;
    chain_last    = 1'b0;
    items_sent    = 0;
    quiet_cycles  = 0;
    send_idle_pct = 18;
    recv_idle_pct = 70;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    run_random(100);
    send_idle_pct = 70;
    recv_idle_pct = 18;
    run_random(175);
    // no idling; the receiver hold-off starts while the table is being filled
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fill_and_walk();
    run_random(ITEM_TARGET);
    in_valid <= 1'b0;

    // drain what is still due, then watch for stray results
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items and %0d checked results: set, link, follow, find, clear,",
             items_sent, results_seen);
    $display("  full-table walks and loops, under three idle mixes and a %0d-cycle hold-off",
             HOLD_OFF_CYCLES);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule
